[rtl/eased_tween_channel_bank_defines.svh]
// ----------------------------------------------------------------------------
// eased_tween_channel_bank_defines
// Assertion macros used by the checker of the tween channel bank.
// ----------------------------------------------------------------------------
`ifndef EASED_TWEEN_CHANNEL_BANK_DEFINES_SVH
`define EASED_TWEEN_CHANNEL_BANK_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ETCB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ETCB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/etcb_pkg.sv]
// ----------------------------------------------------------------------------
// etcb_pkg
// Types, codes and constants of the eased tween channel bank.
// ----------------------------------------------------------------------------
`default_nettype none

package etcb_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int ID_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int Q_BITS    = 10;
	localparam int Q_ONE     = 1024;
	localparam int MAX_DT    = 60000;
	localparam int CUBE_GAIN = 4;
	localparam int CUBE_SH   = 2 * Q_BITS - $clog2(CUBE_GAIN);
	localparam int DIV_CW    = $clog2(Q_BITS + 1);

	typedef logic [ID_W-1:0] idx_t;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_TICK  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_VALUE   = 2'd0,
		KIND_SUMMARY = 2'd1,
		KIND_QUERY   = 2'd2
	} kind_t;

	localparam logic [2:0] EASE_OUT_QUAD    = 3'd1;
	localparam logic [2:0] EASE_OUT_CUBIC   = 3'd2;
	localparam logic [2:0] EASE_INOUT_CUBIC = 3'd3;

	typedef struct packed {
		op_t                op;
		logic [3:0]         slot;
		logic signed [31:0] start_value;
		logic signed [31:0] end_value;
		logic [31:0]        duration;
		logic [2:0]         ease_mode;
		logic               complete;
		logic [31:0]        now_ms;
	} cmd_t;

	typedef struct packed {
		logic [3:0]         out_slot;
		kind_t              kind;
		logic signed [31:0] value;
		logic               done_res;
		logic               flag;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [31:0] start_value;
		logic [31:0] end_value;
		logic [31:0] shown_value;
		logic [31:0] start_time;
		logic [31:0] duration;
		logic [2:0]  ease;
	} slot_rec_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_START_END,
		ST_STOP_RD,
		ST_STOP_WB,
		ST_QUERY,
		ST_SCAN,
		ST_LOAD,
		ST_DIV,
		ST_SQ,
		ST_CUBE,
		ST_SHAPE,
		ST_MUL,
		ST_LERP,
		ST_WB
	} state_t;

endpackage

`default_nettype wire

[rtl/etcb_ram.sv]
// ----------------------------------------------------------------------------
// etcb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module etcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/eased_tween_channel_bank.sv]
// Start: result from ST_START, and for an immediate start one more from ST_START_END. Stop:
// ST_STOP_RD, ST_STOP_WB. Query: ST_QUERY. Tick: ST_SCAN per idle slot; a running one adds
// ST_LOAD, ST_DIV (restoring divider), ST_SQ to ST_LERP (easing, lerp multiplies), ST_WB;
// a finishing one ST_LOAD, ST_WB; then the summary. One request at a time, busy high
// meanwhile. Reset clears all slots to inactive; the slot record RAM needs no clearing.
// ----------------------------------------------------------------------------
// eased_tween_channel_bank
// Bank of tween slots with easing, kept in one record RAM walked by a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module eased_tween_channel_bank (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire etcb_pkg::cmd_t  cmd,
	output etcb_pkg::res_t       result,
	output logic                 result_strobe
);

	etcb_pkg::state_t    state_q, state_d;
	etcb_pkg::cmd_t      req_q;
	logic [etcb_pkg::NUM_SLOTS-1:0] active_q;
	logic [etcb_pkg::CNT_W-1:0]     i_q;
	logic                any_q;
	logic [etcb_pkg::DIV_CW-1:0]    div_cnt_q;

	etcb_pkg::slot_rec_t rec_q, rd_data, wr_data;
	logic                ram_we;
	etcb_pkg::idx_t      ram_waddr, ram_raddr;

	logic [32:0]         rem_q;
	logic [9:0]          quo_q;
	logic [10:0]         x_q, x_d;
	logic [21:0]         sq_q;
	logic [32:0]         cube_q;
	logic [10:0]         p_q, p_d;
	logic signed [44:0]  prod_q;
	logic [31:0]         v_q;
	logic                fin_q;

	logic                out_v;
	etcb_pkg::res_t      out_d;
	logic                act_set, act_clr;
	etcb_pkg::idx_t      act_idx;

	etcb_pkg::idx_t      req_idx, scan_idx;
	logic                req_valid, scan_done;
	logic                immediate;
	logic [31:0]         el;
	logic                fin;
	logic [32:0]         r2;
	logic                qbit;
	logic signed [32:0]  diff;
	logic signed [44:0]  q_wide;
	logic [31:0]         lerp_v;

	assign req_idx   = etcb_pkg::idx_t'(req_q.slot);
	assign req_valid = (6'(req_q.slot) < 6'(etcb_pkg::NUM_SLOTS));
	assign scan_idx  = i_q[etcb_pkg::ID_W-1:0];
	assign scan_done = (i_q == etcb_pkg::CNT_W'(etcb_pkg::NUM_SLOTS));
	assign immediate = (req_q.duration == 32'd0) || (req_q.start_value == req_q.end_value);
	assign busy      = (state_q != etcb_pkg::ST_IDLE);

	etcb_ram #(
		.WIDTH ($bits(etcb_pkg::slot_rec_t)),
		.DEPTH (etcb_pkg::NUM_SLOTS)
	) u_rec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_data),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	assign ram_raddr = (state_q == etcb_pkg::ST_SCAN) ? scan_idx : req_idx;

	// Elapsed time of the record just read; long gaps count as finished.
	always_comb begin
		el = req_q.now_ms - rd_data.start_time;
		if (el > 32'(etcb_pkg::MAX_DT)) begin
			el = rd_data.duration;
		end
		fin = (el >= rd_data.duration);
	end

	// One restoring divider step; the remainder stays below the duration.
	always_comb begin
		r2   = {rem_q[31:0], 1'b0};
		qbit = (r2 >= {1'b0, rec_q.duration});
	end

	always_comb begin
		if ((rec_q.ease == etcb_pkg::EASE_INOUT_CUBIC) && !quo_q[9]) begin
			x_d = {1'b0, quo_q};
		end else begin
			x_d = 11'(etcb_pkg::Q_ONE) - {1'b0, quo_q};
		end
	end

	always_comb begin
		unique case (rec_q.ease)
			etcb_pkg::EASE_OUT_QUAD:
				p_d = 11'(etcb_pkg::Q_ONE) - 11'(sq_q >> etcb_pkg::Q_BITS);
			etcb_pkg::EASE_OUT_CUBIC:
				p_d = 11'(etcb_pkg::Q_ONE) - 11'(cube_q >> (2 * etcb_pkg::Q_BITS));
			etcb_pkg::EASE_INOUT_CUBIC: begin
				if (!quo_q[9]) begin
					p_d = 11'(cube_q >> etcb_pkg::CUBE_SH);
				end else begin
					p_d = 11'(etcb_pkg::Q_ONE) - 11'(cube_q >> etcb_pkg::CUBE_SH);
				end
			end
			default:
				p_d = {1'b0, quo_q};
		endcase
	end

	// The product is divided by 1024 with truncation toward zero.
	always_comb begin
		diff = 33'(signed'(rec_q.end_value)) - 33'(signed'(rec_q.start_value));
		if (prod_q[44]) begin
			q_wide = (prod_q + 45'sd1023) >>> etcb_pkg::Q_BITS;
		end else begin
			q_wide = prod_q >>> etcb_pkg::Q_BITS;
		end
		lerp_v = rec_q.start_value + q_wide[31:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			etcb_pkg::ST_IDLE: begin
				if (start) begin
					unique case (cmd.op)
						etcb_pkg::OP_START: begin
							if (6'(cmd.slot) < 6'(etcb_pkg::NUM_SLOTS)) begin
								state_d = etcb_pkg::ST_START;
							end
						end
						etcb_pkg::OP_STOP:  state_d = etcb_pkg::ST_STOP_RD;
						etcb_pkg::OP_TICK:  state_d = etcb_pkg::ST_SCAN;
						etcb_pkg::OP_QUERY: state_d = etcb_pkg::ST_QUERY;
					endcase
				end
			end
			etcb_pkg::ST_START:
				state_d = immediate ? etcb_pkg::ST_START_END : etcb_pkg::ST_IDLE;
			etcb_pkg::ST_START_END: state_d = etcb_pkg::ST_IDLE;
			etcb_pkg::ST_STOP_RD: begin
				if (req_valid && active_q[req_idx]) begin
					state_d = etcb_pkg::ST_STOP_WB;
				end else begin
					state_d = etcb_pkg::ST_IDLE;
				end
			end
			etcb_pkg::ST_STOP_WB: state_d = etcb_pkg::ST_IDLE;
			etcb_pkg::ST_QUERY:   state_d = etcb_pkg::ST_IDLE;
			etcb_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = etcb_pkg::ST_IDLE;
				end else if (active_q[scan_idx]) begin
					state_d = etcb_pkg::ST_LOAD;
				end
			end
			etcb_pkg::ST_LOAD: state_d = fin ? etcb_pkg::ST_WB : etcb_pkg::ST_DIV;
			etcb_pkg::ST_DIV: begin
				if (div_cnt_q == etcb_pkg::DIV_CW'(etcb_pkg::Q_BITS - 1)) begin
					state_d = etcb_pkg::ST_SQ;
				end
			end
			etcb_pkg::ST_SQ:    state_d = etcb_pkg::ST_CUBE;
			etcb_pkg::ST_CUBE:  state_d = etcb_pkg::ST_SHAPE;
			etcb_pkg::ST_SHAPE: state_d = etcb_pkg::ST_MUL;
			etcb_pkg::ST_MUL:   state_d = etcb_pkg::ST_LERP;
			etcb_pkg::ST_LERP:  state_d = etcb_pkg::ST_WB;
			etcb_pkg::ST_WB:    state_d = etcb_pkg::ST_SCAN;
			default:            state_d = etcb_pkg::ST_IDLE;
		endcase
	end

	// Outputs: result request, RAM write and active bit updates.
	always_comb begin
		out_v     = 1'b0;
		out_d     = '0;
		ram_we    = 1'b0;
		ram_waddr = req_idx;
		wr_data   = rd_data;
		act_set   = 1'b0;
		act_clr   = 1'b0;
		act_idx   = req_idx;
		unique case (state_q)
			etcb_pkg::ST_START: begin
				ram_we              = 1'b1;
				wr_data.start_value = req_q.start_value;
				wr_data.end_value   = req_q.end_value;
				wr_data.shown_value = req_q.start_value;
				wr_data.start_time  = req_q.now_ms;
				wr_data.duration    = req_q.duration;
				wr_data.ease        = req_q.ease_mode;
				act_set             = !immediate;
				act_clr             = immediate;
				out_v               = 1'b1;
				out_d.out_slot      = req_q.slot;
				out_d.kind          = etcb_pkg::KIND_VALUE;
				out_d.value         = req_q.start_value;
				out_d.last          = !immediate;
			end
			etcb_pkg::ST_START_END: begin
				out_v          = 1'b1;
				out_d.out_slot = req_q.slot;
				out_d.kind     = etcb_pkg::KIND_VALUE;
				out_d.value    = req_q.end_value;
				out_d.done_res = 1'b1;
				out_d.last     = 1'b1;
			end
			etcb_pkg::ST_STOP_WB: begin
				act_clr = 1'b1;
				if (req_q.complete) begin
					ram_we              = 1'b1;
					wr_data.shown_value = rd_data.end_value;
					out_v               = 1'b1;
					out_d.out_slot      = req_q.slot;
					out_d.kind          = etcb_pkg::KIND_VALUE;
					out_d.value         = rd_data.end_value;
					out_d.done_res      = 1'b1;
					out_d.last          = 1'b1;
				end
			end
			etcb_pkg::ST_QUERY: begin
				out_v          = 1'b1;
				out_d.out_slot = req_q.slot;
				out_d.kind     = etcb_pkg::KIND_QUERY;
				out_d.flag     = req_valid && active_q[req_idx];
				out_d.last     = 1'b1;
			end
			etcb_pkg::ST_SCAN: begin
				if (scan_done) begin
					out_v      = 1'b1;
					out_d.kind = etcb_pkg::KIND_SUMMARY;
					out_d.flag = any_q;
					out_d.last = 1'b1;
				end
			end
			etcb_pkg::ST_WB: begin
				ram_waddr = scan_idx;
				act_idx   = scan_idx;
				act_clr   = fin_q;
				if ((v_q != rec_q.shown_value) || fin_q) begin
					ram_we              = 1'b1;
					wr_data             = rec_q;
					wr_data.shown_value = v_q;
					out_v               = 1'b1;
					out_d.out_slot      = 4'(scan_idx);
					out_d.kind          = etcb_pkg::KIND_VALUE;
					out_d.value         = v_q;
					out_d.done_res      = fin_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= etcb_pkg::ST_IDLE;
			active_q      <= '0;
			i_q           <= '0;
			any_q         <= 1'b0;
			div_cnt_q     <= '0;
			result_strobe <= 1'b0;
		end else begin
			state_q       <= state_d;
			result_strobe <= out_v;
			if (act_set) begin
				active_q[act_idx] <= 1'b1;
			end else if (act_clr) begin
				active_q[act_idx] <= 1'b0;
			end
			if (state_q == etcb_pkg::ST_IDLE) begin
				i_q   <= '0;
				any_q <= 1'b0;
			end else if (state_q == etcb_pkg::ST_SCAN) begin
				if (!scan_done && !active_q[scan_idx]) begin
					i_q <= i_q + 1'b1;
				end
			end else if (state_q == etcb_pkg::ST_WB) begin
				i_q <= i_q + 1'b1;
				if (out_v) begin
					any_q <= 1'b1;
				end
			end
			if (state_q == etcb_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_v) begin
			result <= out_d;
		end
		if (start && !busy) begin
			req_q <= cmd;
		end
		unique case (state_q)
			etcb_pkg::ST_LOAD: begin
				rec_q <= rd_data;
				rem_q <= {1'b0, el};
				quo_q <= '0;
				fin_q <= fin;
				v_q   <= rd_data.end_value;
			end
			etcb_pkg::ST_DIV: begin
				rem_q <= qbit ? (r2 - {1'b0, rec_q.duration}) : r2;
				quo_q <= {quo_q[8:0], qbit};
			end
			etcb_pkg::ST_SQ: begin
				x_q  <= x_d;
				sq_q <= x_d * x_d;
			end
			etcb_pkg::ST_CUBE:  cube_q <= sq_q * 33'(x_q);
			etcb_pkg::ST_SHAPE: p_q <= p_d;
			etcb_pkg::ST_MUL:   prod_q <= 45'(diff) * 45'(signed'({1'b0, p_q}));
			etcb_pkg::ST_LERP:  v_q <= lerp_v;
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/etcb_checker.sv]
// ----------------------------------------------------------------------------
// etcb_checker
// Port-level checks of the tween channel bank result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "eased_tween_channel_bank_defines.svh"

module etcb_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire etcb_pkg::cmd_t cmd,
	input wire etcb_pkg::res_t result,
	input wire logic           result_strobe
);

	// A result that is not the last one means the request is still in work.
	`ETCB_ASSERT_IMP(a_more_busy, result_strobe && !result.last, busy, "non-final result while idle")
	`ETCB_ASSERT_NXT(a_last_gap, result_strobe && result.last, !result_strobe, "result right after final result")
	`ETCB_ASSERT_IMP(a_summary, result_strobe && (result.kind == etcb_pkg::KIND_SUMMARY), result.last && (result.out_slot == 4'd0) && (result.value == 32'sd0), "malformed tick summary")
	`ETCB_ASSERT_IMP(a_query, result_strobe && (result.kind == etcb_pkg::KIND_QUERY), result.last && $past(start && !busy && (cmd.op == etcb_pkg::OP_QUERY), 2), "query answer without query request")

endmodule

bind eased_tween_channel_bank etcb_checker u_etcb_checker (.*);

`default_nettype wire
